// ----- design/fsc_pkg.sv -----
// ----------------------------------------------------------------------------
// fsc_pkg: shared types and constants of the frustum sphere culler
// Beat types, operation codes and the corner and plane tables.
// ----------------------------------------------------------------------------
package fsc_pkg;

  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned PLANE_COUNT   = 6;
  localparam int unsigned QDEPTH        = 4;

  localparam logic [1:0] ACT_LOAD    = 2'd0;
  localparam logic [1:0] ACT_REBUILD = 2'd1;
  localparam logic [1:0] ACT_TEST    = 2'd2;

  localparam logic [2:0] PLANE_NONE = 3'(PLANE_COUNT);

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_REBUILD,
    OP_TEST
  } op_e;

  typedef struct packed {
    logic [1:0]         action;
    logic [1:0]         row_index;
    logic signed [31:0] row_col0;
    logic signed [31:0] row_col1;
    logic signed [31:0] row_col2;
    logic signed [31:0] row_col3;
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] center_z;
    logic [30:0]        sphere_radius;
    logic               has_bounds;
  } in_t;

  typedef struct packed {
    logic       visible;
    logic [2:0] culling_plane;
  } res_t;

  typedef struct packed {
    op_e op;
    in_t item;
  } cmd_t;

  // Per corner: {negate x row, negate y row, add z row}.
  localparam logic [2:0] CORNER_SIGN [8] = '{
    3'b100, 3'b000, 3'b010, 3'b110, 3'b101, 3'b001, 3'b011, 3'b111
  };

  // Corners a, b, c of each plane: near, far, top, bottom, left, right.
  localparam logic [2:0] PLANE_PTS [6][3] = '{
    '{3'd0, 3'd1, 3'd2}, '{3'd4, 3'd7, 3'd5}, '{3'd4, 3'd5, 3'd1},
    '{3'd7, 3'd3, 3'd6}, '{3'd4, 3'd0, 3'd7}, '{3'd5, 3'd6, 3'd1}
  };

endpackage

// ----- design/fsc_queue.sv -----
// ----------------------------------------------------------------------------
// fsc_queue: command queue
// Small register queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module fsc_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  fsc_pkg::cmd_t data_i,
  input  logic          pop_i,
  output fsc_pkg::cmd_t data_o,
  output logic          empty_o,
  output logic          full_o
);

  localparam int unsigned AW = $clog2(fsc_pkg::QDEPTH);

  fsc_pkg::cmd_t mem_q [fsc_pkg::QDEPTH];
  logic [AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [AW:0]   cnt_q;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == (AW+1)'(fsc_pkg::QDEPTH));
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("Push into a full queue.");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("Pop from an empty queue.");
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (AW+1)'(fsc_pkg::QDEPTH)) else $error("Queue count out of range.");

endmodule

// ----- design/fsc_front.sv -----
// ----------------------------------------------------------------------------
// fsc_front: command front end
// Accepts input beats, decodes the action and queues the command.
// ----------------------------------------------------------------------------
module fsc_front (
  input  fsc_pkg::in_t  item_i,
  input  logic          start_i,
  input  logic          full_i,
  output logic          push_o,
  output fsc_pkg::cmd_t cmd_o,
  output logic          busy_o
);

  logic known;

  always_comb begin
    cmd_o.item = item_i;
    cmd_o.op   = fsc_pkg::OP_LOAD;
    known      = 1'b1;
    case (item_i.action)
      fsc_pkg::ACT_LOAD:    cmd_o.op = fsc_pkg::OP_LOAD;
      fsc_pkg::ACT_REBUILD: cmd_o.op = fsc_pkg::OP_REBUILD;
      fsc_pkg::ACT_TEST:    cmd_o.op = fsc_pkg::OP_TEST;
      default:              known    = 1'b0;
    endcase
  end

  assign busy_o = full_i;
  assign push_o = start_i && !full_i && known;

endmodule

// ----- design/fsc_back.sv -----
// ----------------------------------------------------------------------------
// fsc_back: command back end
// Sequencer with a shared multiplier, a bit-serial divider and a bit-pair
// square root that loads the matrix, rebuilds the planes and tests spheres.
// ----------------------------------------------------------------------------
module fsc_back #(
  parameter int unsigned FRAC_BITS = fsc_pkg::FRAC_BITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  fsc_pkg::cmd_t cmd_i,
  input  logic          empty_i,
  output logic          pop_o,
  output logic          res_valid_o,
  output fsc_pkg::res_t res_o
);

  localparam int unsigned DSW = 34;
  localparam int unsigned DVW = DSW + FRAC_BITS;
  localparam int unsigned DCW = $clog2(DVW + 1);
  localparam int unsigned NP  = fsc_pkg::PLANE_COUNT;
  localparam logic [DVW-1:0] Q_LIM = {{(DVW-32){1'b0}}, 32'h8000_0000};

  typedef enum logic [3:0] {
    S_IDLE, S_TEST, S_CORNER, S_PERSP, S_DIV, S_PSTORE, S_PA, S_PB,
    S_PC, S_CROSS, S_NORM, S_SQ, S_SQRT, S_NDIV, S_NSTORE, S_DOT
  } st_e;

  function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
    if (v[32] != v[31]) begin
      sat33 = v[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      sat33 = v[31:0];
    end
  endfunction

  function automatic logic signed [31:0] sat66(input logic signed [65:0] v);
    if ((&v[65:31]) || !(|v[65:31])) begin
      sat66 = v[31:0];
    end else begin
      sat66 = v[65] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end
  endfunction

  st_e                st_q, ret_q;
  logic signed [31:0] mat_q [16];
  logic signed [31:0] wp_q [8][3];
  logic signed [31:0] pl_q [4*NP];
  logic [2:0]         k_q, p_q, stp_q;
  logic [1:0]         c_q;
  logic signed [34:0] v_q [4];
  logic signed [31:0] a_q [3];
  logic signed [31:0] b_q [3];
  logic signed [31:0] e1_q [3];
  logic signed [31:0] e2_q [3];
  logic signed [31:0] n_q [3];
  logic signed [31:0] cx_q, cy_q, cz_q;
  logic [30:0]        rad_q;
  logic signed [63:0] prod_q;
  logic signed [64:0] acc_q;
  logic [63:0]        m_q [3];
  logic [2:0]         neg_q;
  logic               pneg_q;
  logic [63:0]        sq_n_q, sq_res_q, sq_bit_q;
  logic [DSW-1:0]     div_rem_q, div_den_q;
  logic [DVW-1:0]     div_quo_q;
  logic [DCW-1:0]     div_cnt_q;
  logic               res_valid_q;
  fsc_pkg::res_t      res_q;

  logic signed [34:0] v_new [4];
  logic [2:0]         csgn;
  logic signed [34:0] num, den, num_mag, den_mag;
  logic signed [31:0] den0_res, persp_res;
  logic [DSW:0]       div_t;
  logic               div_ge;
  logic [DSW-1:0]     div_rem_d;
  logic [DVW-1:0]     div_quo_d;
  logic [2:0]         wsel;
  logic signed [31:0] wrd [3];
  logic signed [64:0] cdiff;
  logic [63:0]        cmag, mx;
  logic [63:0]        sq_t;
  logic [1:0]         msel, pi;
  logic signed [31:0] pl_rd, mul_a, mul_b;
  logic signed [64:0] sum, rad_s, sh;
  logic signed [65:0] nd;
  logic signed [31:0] q32;

  always_comb begin
    csgn = fsc_pkg::CORNER_SIGN[k_q];
    for (int c = 0; c < 4; c++) begin
      v_new[c] = 35'(mat_q[12+c])
               + (csgn[2] ? -35'(mat_q[c]) : 35'(mat_q[c]))
               + (csgn[1] ? -35'(mat_q[4+c]) : 35'(mat_q[4+c]))
               + (csgn[0] ? 35'(mat_q[8+c]) : 35'sd0);
    end
  end

  assign num     = v_q[c_q];
  assign den     = v_q[3];
  assign num_mag = num[34] ? -num : num;
  assign den_mag = den[34] ? -den : den;
  assign den0_res = (num > 35'sd0) ? 32'sh7FFF_FFFF :
                    (num < 35'sd0) ? 32'sh8000_0000 : 32'sd0;

  assign div_t     = {div_rem_q, div_quo_q[DVW-1]};
  assign div_ge    = div_t >= {1'b0, div_den_q};
  assign div_rem_d = div_ge ? DSW'(div_t - {1'b0, div_den_q}) : div_t[DSW-1:0];
  assign div_quo_d = {div_quo_q[DVW-2:0], div_ge};

  always_comb begin
    if (pneg_q) begin
      persp_res = (div_quo_q >= Q_LIM) ? 32'sh8000_0000
                                       : $signed(32'(~div_quo_q[31:0] + 32'd1));
    end else begin
      persp_res = (div_quo_q >= Q_LIM) ? 32'sh7FFF_FFFF : $signed(div_quo_q[31:0]);
    end
  end

  assign q32 = $signed(div_quo_q[31:0]);

  always_comb begin
    case (st_q)
      S_PA:    wsel = fsc_pkg::PLANE_PTS[p_q][0];
      S_PB:    wsel = fsc_pkg::PLANE_PTS[p_q][1];
      default: wsel = fsc_pkg::PLANE_PTS[p_q][2];
    endcase
    for (int i = 0; i < 3; i++) begin
      wrd[i] = wp_q[wsel][i];
    end
  end

  assign cdiff = acc_q - 65'(prod_q);
  assign cmag  = cdiff[64] ? 64'(-cdiff) : 64'(cdiff);

  always_comb begin
    mx = m_q[0];
    if (m_q[1] > mx) begin
      mx = m_q[1];
    end
    if (m_q[2] > mx) begin
      mx = m_q[2];
    end
  end

  assign sq_t = sq_res_q + sq_bit_q;

  always_comb begin
    if (st_q == S_NDIV || st_q == S_NSTORE) begin
      msel = c_q;
    end else begin
      msel = (stp_q < 3'd3) ? stp_q[1:0] : 2'd0;
    end
    pi    = (stp_q == 3'd0) ? 2'd3 : 2'(stp_q - 3'd1);
    pl_rd = pl_q[{p_q, pi}];
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (st_q)
      S_CROSS: begin
        case (stp_q)
          3'd0:    begin mul_a = e1_q[1]; mul_b = e2_q[2]; end
          3'd1:    begin mul_a = e1_q[2]; mul_b = e2_q[1]; end
          3'd2:    begin mul_a = e1_q[2]; mul_b = e2_q[0]; end
          3'd3:    begin mul_a = e1_q[0]; mul_b = e2_q[2]; end
          3'd4:    begin mul_a = e1_q[0]; mul_b = e2_q[1]; end
          3'd5:    begin mul_a = e1_q[1]; mul_b = e2_q[0]; end
          default: ;
        endcase
      end
      S_SQ: begin
        mul_a = $signed({2'b00, m_q[msel][29:0]});
        mul_b = $signed({2'b00, m_q[msel][29:0]});
      end
      S_DOT: begin
        mul_a = n_q[msel];
        mul_b = a_q[msel];
      end
      S_TEST: begin
        mul_a = pl_rd;
        case (stp_q)
          3'd1:    mul_b = cx_q;
          3'd2:    mul_b = cy_q;
          3'd3:    mul_b = cz_q;
          default: mul_b = '0;
        endcase
      end
      default: ;
    endcase
  end

  assign sum   = acc_q + 65'(prod_q);
  assign rad_s = $signed({34'd0, rad_q}) <<< FRAC_BITS;
  assign sh    = sum >>> FRAC_BITS;
  assign nd    = -$signed({sh[64], sh});

  assign pop_o = (st_q == S_IDLE) && !empty_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_IDLE;
      ret_q       <= S_IDLE;
      mat_q       <= '{default: '0};
      wp_q        <= '{default: '{default: '0}};
      pl_q        <= '{default: '0};
      k_q         <= '0;
      p_q         <= '0;
      stp_q       <= '0;
      c_q         <= '0;
      v_q         <= '{default: '0};
      a_q         <= '{default: '0};
      b_q         <= '{default: '0};
      e1_q        <= '{default: '0};
      e2_q        <= '{default: '0};
      n_q         <= '{default: '0};
      cx_q        <= '0;
      cy_q        <= '0;
      cz_q        <= '0;
      rad_q       <= '0;
      prod_q      <= '0;
      acc_q       <= '0;
      m_q         <= '{default: '0};
      neg_q       <= '0;
      pneg_q      <= 1'b0;
      sq_n_q      <= '0;
      sq_res_q    <= '0;
      sq_bit_q    <= '0;
      div_rem_q   <= '0;
      div_den_q   <= '0;
      div_quo_q   <= '0;
      div_cnt_q   <= '0;
      res_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      prod_q      <= mul_a * mul_b;
      res_valid_q <= 1'b0;
      case (st_q)
        S_IDLE: begin
          if (!empty_i) begin
            case (cmd_i.op)
              fsc_pkg::OP_LOAD: begin
                mat_q[{cmd_i.item.row_index, 2'd0}] <= cmd_i.item.row_col0;
                mat_q[{cmd_i.item.row_index, 2'd1}] <= cmd_i.item.row_col1;
                mat_q[{cmd_i.item.row_index, 2'd2}] <= cmd_i.item.row_col2;
                mat_q[{cmd_i.item.row_index, 2'd3}] <= cmd_i.item.row_col3;
              end
              fsc_pkg::OP_REBUILD: begin
                k_q  <= '0;
                c_q  <= '0;
                st_q <= S_CORNER;
              end
              fsc_pkg::OP_TEST: begin
                if (!cmd_i.item.has_bounds) begin
                  res_valid_q         <= 1'b1;
                  res_q.visible       <= 1'b1;
                  res_q.culling_plane <= fsc_pkg::PLANE_NONE;
                end else begin
                  cx_q  <= cmd_i.item.center_x;
                  cy_q  <= cmd_i.item.center_y;
                  cz_q  <= cmd_i.item.center_z;
                  rad_q <= cmd_i.item.sphere_radius;
                  p_q   <= '0;
                  stp_q <= '0;
                  st_q  <= S_TEST;
                end
              end
              default: ;
            endcase
          end
        end
        S_CORNER: begin
          v_q  <= v_new;
          c_q  <= '0;
          st_q <= S_PERSP;
        end
        S_PERSP: begin
          if (den == 35'sd0) begin
            wp_q[k_q][c_q] <= den0_res;
            if (c_q == 2'd2) begin
              c_q <= '0;
              if (k_q == 3'd7) begin
                p_q  <= '0;
                st_q <= S_PA;
              end else begin
                k_q  <= k_q + 3'd1;
                st_q <= S_CORNER;
              end
            end else begin
              c_q <= c_q + 2'd1;
            end
          end else begin
            div_rem_q <= '0;
            div_quo_q <= DVW'(num_mag[33:0]) << FRAC_BITS;
            div_den_q <= den_mag[33:0];
            div_cnt_q <= DCW'(DVW);
            pneg_q    <= num[34] ^ den[34];
            ret_q     <= S_PSTORE;
            st_q      <= S_DIV;
          end
        end
        S_DIV: begin
          div_rem_q <= div_rem_d;
          div_quo_q <= div_quo_d;
          div_cnt_q <= div_cnt_q - 1'b1;
          if (div_cnt_q == DCW'(1)) begin
            st_q <= ret_q;
          end
        end
        S_PSTORE: begin
          wp_q[k_q][c_q] <= persp_res;
          if (c_q == 2'd2) begin
            c_q <= '0;
            if (k_q == 3'd7) begin
              p_q  <= '0;
              st_q <= S_PA;
            end else begin
              k_q  <= k_q + 3'd1;
              st_q <= S_CORNER;
            end
          end else begin
            c_q  <= c_q + 2'd1;
            st_q <= S_PERSP;
          end
        end
        S_PA: begin
          a_q  <= wrd;
          st_q <= S_PB;
        end
        S_PB: begin
          b_q  <= wrd;
          st_q <= S_PC;
        end
        S_PC: begin
          for (int i = 0; i < 3; i++) begin
            e1_q[i] <= sat33(33'(a_q[i]) - 33'(b_q[i]));
            e2_q[i] <= sat33(33'(a_q[i]) - 33'(wrd[i]));
          end
          stp_q <= '0;
          st_q  <= S_CROSS;
        end
        S_CROSS: begin
          stp_q <= stp_q + 3'd1;
          case (stp_q)
            3'd1, 3'd3, 3'd5: acc_q <= 65'(prod_q);
            3'd2: begin
              m_q[0]   <= cmag;
              neg_q[0] <= cdiff[64];
            end
            3'd4: begin
              m_q[1]   <= cmag;
              neg_q[1] <= cdiff[64];
            end
            3'd6: begin
              m_q[2]   <= cmag;
              neg_q[2] <= cdiff[64];
              st_q     <= S_NORM;
            end
            default: ;
          endcase
        end
        S_NORM: begin
          if (mx == '0) begin
            n_q   <= '{default: '0};
            stp_q <= '0;
            st_q  <= S_DOT;
          end else if (|mx[63:30]) begin
            for (int i = 0; i < 3; i++) begin
              m_q[i] <= m_q[i] >> 1;
            end
          end else if (!(|mx[63:29])) begin
            for (int i = 0; i < 3; i++) begin
              m_q[i] <= m_q[i] << 1;
            end
          end else begin
            stp_q <= '0;
            st_q  <= S_SQ;
          end
        end
        S_SQ: begin
          stp_q <= stp_q + 3'd1;
          case (stp_q)
            3'd1: sq_n_q <= 64'(prod_q);
            3'd2: sq_n_q <= sq_n_q + 64'(prod_q);
            3'd3: begin
              sq_n_q   <= sq_n_q + 64'(prod_q);
              sq_res_q <= '0;
              sq_bit_q <= 64'd1 << 62;
              st_q     <= S_SQRT;
            end
            default: ;
          endcase
        end
        S_SQRT: begin
          if (sq_bit_q == '0) begin
            c_q  <= '0;
            st_q <= S_NDIV;
          end else begin
            if (sq_n_q >= sq_t) begin
              sq_n_q   <= sq_n_q - sq_t;
              sq_res_q <= (sq_res_q >> 1) + sq_bit_q;
            end else begin
              sq_res_q <= sq_res_q >> 1;
            end
            sq_bit_q <= sq_bit_q >> 2;
          end
        end
        S_NDIV: begin
          div_rem_q <= '0;
          div_quo_q <= DVW'(m_q[msel][29:0]) << FRAC_BITS;
          div_den_q <= DSW'(sq_res_q[31:0]);
          div_cnt_q <= DCW'(DVW);
          ret_q     <= S_NSTORE;
          st_q      <= S_DIV;
        end
        S_NSTORE: begin
          n_q[c_q] <= neg_q[c_q] ? -q32 : q32;
          if (c_q == 2'd2) begin
            stp_q <= '0;
            st_q  <= S_DOT;
          end else begin
            c_q  <= c_q + 2'd1;
            st_q <= S_NDIV;
          end
        end
        S_DOT: begin
          stp_q <= stp_q + 3'd1;
          case (stp_q)
            3'd1: acc_q <= 65'(prod_q);
            3'd2: acc_q <= sum;
            3'd3: begin
              pl_q[{p_q, 2'd0}] <= n_q[0];
              pl_q[{p_q, 2'd1}] <= n_q[1];
              pl_q[{p_q, 2'd2}] <= n_q[2];
              pl_q[{p_q, 2'd3}] <= sat66(nd);
              stp_q <= '0;
              if (p_q == 3'(NP - 1)) begin
                st_q <= S_IDLE;
              end else begin
                p_q  <= p_q + 3'd1;
                st_q <= S_PA;
              end
            end
            default: ;
          endcase
        end
        S_TEST: begin
          stp_q <= stp_q + 3'd1;
          case (stp_q)
            3'd0: acc_q <= 65'(pl_rd) <<< FRAC_BITS;
            3'd2, 3'd3: acc_q <= sum;
            3'd4: begin
              stp_q <= '0;
              if (sum > rad_s) begin
                res_valid_q         <= 1'b1;
                res_q.visible       <= 1'b0;
                res_q.culling_plane <= p_q;
                st_q                <= S_IDLE;
              end else if (p_q == 3'(NP - 1)) begin
                res_valid_q         <= 1'b1;
                res_q.visible       <= 1'b1;
                res_q.culling_plane <= fsc_pkg::PLANE_NONE;
                st_q                <= S_IDLE;
              end else begin
                p_q <= p_q + 3'd1;
              end
            end
            default: ;
          endcase
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  a_res_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> (res_q.visible == (res_q.culling_plane == fsc_pkg::PLANE_NONE)))
    else $error("Result plane code disagrees with visibility.");
  a_len_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_NDIV) |-> (sq_res_q != '0))
    else $error("Normal divide started with a zero length.");
  a_div_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_DIV) |-> (div_den_q != '0))
    else $error("Divider running with a zero divisor.");

endmodule

// ----- design/frustum_sphere_cull.sv -----
// ----------------------------------------------------------------------------
// frustum_sphere_cull: view-frustum culling of bounding spheres
// Holds an inverse view-projection matrix, rebuilds six frustum planes from
// it and tests bounding spheres against them, all in signed fixed point.
// ----------------------------------------------------------------------------
//   Channel  Ports                        Handshake
//   input    item_i, start, busy          beat taken when start and not busy
//   result   result_o, result_valid_o     beat shown for one cycle, no stall
//
// A load beat and a test without bounds finish in the dispatch state; a test
// with bounds checks the planes in order and stops at the first culling plane.
// A rebuild is bound by the bit-serial divider (34 + FRAC_BITS quotient bits,
// up to 42 quotients per rebuild).
// Commands wait in a 4-deep queue; busy is high while it is full.
// Reset clears the planes to zero, so every sphere is visible until a rebuild.
// ----------------------------------------------------------------------------
module frustum_sphere_cull #(
  parameter int unsigned FRAC_BITS = fsc_pkg::FRAC_BITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  fsc_pkg::in_t  item_i,
  output logic          result_valid_o,
  output fsc_pkg::res_t result_o
);

  fsc_pkg::cmd_t push_cmd, head_cmd;
  logic          push, pop, empty, full;

  fsc_front u_front (
    .item_i  (item_i),
    .start_i (start),
    .full_i  (full),
    .push_o  (push),
    .cmd_o   (push_cmd),
    .busy_o  (busy)
  );

  fsc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_cmd),
    .pop_i   (pop),
    .data_o  (head_cmd),
    .empty_o (empty),
    .full_o  (full)
  );

  fsc_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (head_cmd),
    .empty_i     (empty),
    .pop_o       (pop),
    .res_valid_o (result_valid_o),
    .res_o       (result_o)
  );

endmodule
